// ----- rtl/assert_macros.svh -----
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the following cycle, also while reset is high
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

// implication checked in the following cycle, masked during reset
`define ASSERT_NEXT_RUN(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/cesd_pkg.sv -----
// shared types and constants for the escape sequence decoder
`default_nettype none

package cesd_pkg;

  // most result bytes one input byte can produce
  localparam int MAX_RES   = 4;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W = $clog2(MAX_RES);

  // one decoded byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cesd_res_t;

  // all results of one input byte, slot 0 first
  typedef struct packed {
    logic [RES_CNT_W-1:0]      cnt;
    cesd_res_t [MAX_RES-1:0]   res;
  } cesd_batch_t;

endpackage

`default_nettype wire

// ----- rtl/cesd_if.sv -----
// stream interfaces for raw and decoded bytes
`default_nettype none

interface cesd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface cesd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/cesd_decode.sv -----
// escape decoding state and per-byte result logic
`default_nettype none

module cesd_decode import cesd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output cesd_batch_t      batch
);

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_HEX0  = 2'd2;
  localparam logic [1:0] MODE_HEX1  = 2'd3;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPR_A = 8'h41;
  localparam logic [7:0] CH_UPR_F = 8'h46;
  localparam logic [7:0] CH_LWR_A = 8'h61;
  localparam logic [7:0] CH_LWR_F = 8'h66;
  localparam logic [7:0] CH_LWR_B = 8'h62;
  localparam logic [7:0] CH_LWR_N = 8'h6E;
  localparam logic [7:0] CH_LWR_R = 8'h72;
  localparam logic [7:0] CH_LWR_T = 8'h74;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  logic [1:0] mode;
  logic [1:0] mode_next;
  logic [7:0] first_hex;
  logic [7:0] first_hex_next;

  function automatic logic is_hex(input logic [7:0] b);
    return b inside {[CH_ZERO:CH_NINE], [CH_UPR_A:CH_UPR_F], [CH_LWR_A:CH_LWR_F]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (b <= CH_NINE) begin
      v = b - CH_ZERO;
    end else if (b <= CH_UPR_F) begin
      v = b - CH_UPR_A + HEX_TEN;
    end else begin
      v = b - CH_LWR_A + HEX_TEN;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      CH_ZERO:  r = 8'h00;
      CH_LWR_A: r = 8'o007;
      CH_LWR_B: r = 8'h08;
      CH_LWR_F: r = 8'o014;
      CH_LWR_N: r = 8'd10;
      CH_LWR_R: r = 8'h0D;
      CH_LWR_T: r = 8'h09;
      default:  r = b;
    endcase
    return r;
  endfunction

  // per-mode result slots and next state
  always_comb begin
    logic plain_hold;
    plain_hold     = (in_byte == CH_BSL) && !in_last;
    batch          = '0;
    mode_next      = mode;
    first_hex_next = first_hex;
    case (mode)
      MODE_PLAIN: begin
        if (plain_hold) begin
          mode_next = MODE_ESC;
        end else begin
          batch.res[0] = '{data: in_byte, last: in_last};
          batch.cnt    = RES_CNT_W'(1);
          mode_next    = MODE_PLAIN;
        end
      end
      MODE_ESC: begin
        if (in_byte == CH_X) begin
          if (in_last) begin
            batch.res[0] = '{data: CH_BSL, last: 1'b0};
            batch.res[1] = '{data: CH_X, last: 1'b1};
            batch.cnt    = RES_CNT_W'(2);
            mode_next    = MODE_PLAIN;
          end else begin
            mode_next = MODE_HEX0;
          end
        end else begin
          batch.res[0] = '{data: esc_map(in_byte), last: in_last};
          batch.cnt    = RES_CNT_W'(1);
          mode_next    = MODE_PLAIN;
        end
      end
      MODE_HEX0: begin
        if (is_hex(in_byte) && !in_last) begin
          first_hex_next = in_byte;
          mode_next      = MODE_HEX1;
        end else begin
          // bad hex escape: backslash, x, then the byte as plain text unless it opens a new escape
          batch.res[0] = '{data: CH_BSL, last: 1'b0};
          batch.res[1] = '{data: CH_X, last: 1'b0};
          if (plain_hold) begin
            batch.cnt = RES_CNT_W'(2);
            mode_next = MODE_ESC;
          end else begin
            batch.res[2] = '{data: in_byte, last: in_last};
            batch.cnt    = RES_CNT_W'(3);
            mode_next    = MODE_PLAIN;
          end
        end
      end
      MODE_HEX1: begin
        if (is_hex(in_byte)) begin
          batch.res[0] = '{data: {hex_val(first_hex), hex_val(in_byte)}, last: in_last};
          batch.cnt    = RES_CNT_W'(1);
          mode_next    = MODE_PLAIN;
        end else begin
          // bad hex escape after one digit
          batch.res[0] = '{data: CH_BSL, last: 1'b0};
          batch.res[1] = '{data: CH_X, last: 1'b0};
          batch.res[2] = '{data: first_hex, last: 1'b0};
          if (plain_hold) begin
            batch.cnt = RES_CNT_W'(3);
            mode_next = MODE_ESC;
          end else begin
            batch.res[3] = '{data: in_byte, last: in_last};
            batch.cnt    = RES_CNT_W'(4);
            mode_next    = MODE_PLAIN;
          end
        end
      end
      default: begin
        mode_next = MODE_PLAIN;
      end
    endcase
  end

  // decoder state advances once per consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_PLAIN;
      first_hex <= '0;
    end else if (step) begin
      mode      <= mode_next;
      first_hex <= first_hex_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cesd_outbuf.sv -----
// result register holding one batch, drained one byte per transaction
`default_nettype none

module cesd_outbuf import cesd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire cesd_batch_t batch,
  output logic             load_ok,
  cesd_out_if.source       dout
);

  cesd_res_t            ent [MAX_RES];
  logic [RES_CNT_W-1:0] cnt;
  logic [RES_IDX_W-1:0] rd;
  logic                 pop;

  assign pop     = dout.valid && dout.ready;
  // a new batch fits when empty or once the last held byte leaves this cycle
  assign load_ok = (cnt == '0) || ((cnt == RES_CNT_W'(1)) && dout.ready);

  // output side
  assign dout.valid    = (cnt != '0);
  assign dout.out_byte = ent[rd].data;
  assign dout.out_last = ent[rd].last;

  // count and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd  <= '0;
    end else if (load) begin
      cnt <= batch.cnt;
      rd  <= '0;
    end else if (pop) begin
      cnt <= cnt - RES_CNT_W'(1);
      rd  <= rd + RES_IDX_W'(1);
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        ent[i] <= batch.res[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/c_escape_sequence_decoder.sv -----
// C string escape decoder: raw byte stream in, decoded byte stream out
//
// din carries the escaped string one byte per transaction, in_last on its
// final byte. dout carries the decoded bytes, out_last on the final one.
// An accepted byte is held in the input register, then is decoded and
// loaded into the result register, from which its first result is
// driven on dout. Each raw byte yields zero to four decoded bytes, which
// leave at one per cycle while dout is ready. While dout is ready and
// each byte yields one result, the block takes and delivers a byte every
// cycle; a bad hex escape yields up to four bytes and holds din until
// the extra bytes have left.
// When dout stalls, the result register holds, the input register fills,
// and din.ready falls until dout drains. Synchronous reset empties both
// registers and returns the decoder to plain text.
`default_nettype none

module c_escape_sequence_decoder import cesd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  cesd_in_if.sink    din,
  cesd_out_if.source dout
);

  logic        in_full;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        load_ok;
  logic        step;
  cesd_batch_t batch;

  assign step     = in_full && load_ok;
  assign din.ready = !in_full || load_ok;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (din.valid && din.ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      in_byte_q <= din.in_byte;
      in_last_q <= din.in_last;
    end
  end

  cesd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte_q),
    .in_last (in_last_q),
    .batch   (batch)
  );

  cesd_outbuf u_outbuf (
    .clk     (clk),
    .rst     (rst),
    .load    (step),
    .batch   (batch),
    .load_ok (load_ok),
    .dout    (dout)
  );

endmodule

`default_nettype wire

// ----- rtl/cesd_checker.sv -----
// port-level checks for the escape sequence decoder
`default_nettype none
`include "assert_macros.svh"

module cesd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  // reset empties both registers
  `ASSERT_NEXT(a_rst_out_empty, rst, !out_valid)
  `ASSERT_NEXT(a_rst_in_ready, rst, in_ready)

  // a stalled result transaction holds
  `ASSERT_NEXT_RUN(a_out_hold, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT_RUN(a_out_stable, out_valid && !out_ready, $stable(out_byte) && $stable(out_last))

endmodule

bind c_escape_sequence_decoder cesd_checker u_cesd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_byte  (dout.out_byte),
  .out_last  (dout.out_last)
);

`default_nettype wire
